// ----- sv/sbs_pkg.sv -----
// ============================================================================
// sbs_pkg
// Shared types and constants for the sorted table binary search block.
// ============================================================================
package sbs_pkg;

	// Default sizes of the element table
	localparam int DEPTH_DEF      = 1024;
	localparam int ELEM_WIDTH_DEF = 32;

	// Fixed port widths
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 10;

	// Command codes on the request channel; code 3 is ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_RESULT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;   // empty the table
		logic append;  // write the request word at the fill index
		logic start;   // load key and search bounds
		logic read;    // issue a table read this cycle
		logic probe;   // compare data from the table, narrow or conclude
		logic emit;    // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cnt_zero;    // table is empty
		logic probe_done;  // current probe hits or empties the range
	} dp_status_t;

endpackage

// ----- sv/sbs_ram.sv -----
// ============================================================================
// sbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module sbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/sbs_datapath.sv -----
// ============================================================================
// sbs_datapath
// Element table, fill count, search bounds, probe compare and result registers.
// ============================================================================
module sbs_datapath
	import sbs_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dp_cmd,
	output dp_status_t         dp_status,
	input  logic [VALUE_W-1:0] value,
	output logic               found,
	output logic [POS_W-1:0]   position,
	output logic               full
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         count_q;
	logic [IW-1:0]         lo_q, hi_q, mid_q;
	logic [ELEM_WIDTH-1:0] key_q;
	logic                  res_found_q, found_q;
	logic [POS_W-1:0]      res_pos_q, position_q;

	logic [63:0]           value_ext;
	logic [ELEM_WIDTH-1:0] elem;
	logic [CW-1:0]         cnt_m1, cnt_half;
	logic [IW-1:0]         diff_up, diff_dn, mid_up, mid_dn, mid_nxt, rd_addr;
	logic [ELEM_WIDTH-1:0] rdata;
	logic                  hit, less, can_up, can_dn, done;
	logic [POS_W+IW-1:0]   mid_ext;

	// Sign-extend the request word, then cut to the element width
	assign value_ext = {{(64 - VALUE_W){value[VALUE_W-1]}}, value};
	assign elem      = value_ext[ELEM_WIDTH-1:0];

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_half = count_q >> 1;

	// Both candidate next probes come from registers, in parallel with the read
	assign diff_up = hi_q - mid_q;
	assign diff_dn = mid_q - lo_q;
	assign mid_up  = mid_q + IW'(1) + (diff_up >> 1);
	assign mid_dn  = lo_q + (diff_dn >> 1);
	assign can_up  = mid_q < hi_q;
	assign can_dn  = lo_q < mid_q;

	assign hit  = rdata == key_q;
	assign less = $signed(rdata) < $signed(key_q);
	assign done = hit || (less ? !can_up : !can_dn);

	assign mid_nxt = less ? mid_up : mid_dn;
	assign rd_addr = dp_cmd.probe ? mid_nxt : mid_q;
	assign mid_ext = {{POS_W{1'b0}}, mid_q};

	sbs_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (dp_cmd.append),
		.waddr (count_q[IW-1:0]),
		.wdata (elem),
		.re    (dp_cmd.read),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.clear) begin
			count_q <= '0;
		end else if (dp_cmd.append) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			key_q       <= elem;
			lo_q        <= '0;
			hi_q        <= cnt_m1[IW-1:0];
			mid_q       <= cnt_half[IW-1:0];
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end else if (dp_cmd.probe) begin
			if (done) begin
				res_found_q <= hit;
				res_pos_q   <= hit ? mid_ext[POS_W-1:0] : '0;
			end else if (less) begin
				lo_q  <= mid_q + IW'(1);
				mid_q <= mid_nxt;
			end else begin
				hi_q  <= mid_q - IW'(1);
				mid_q <= mid_nxt;
			end
		end
		if (dp_cmd.emit) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign dp_status.cnt_zero   = count_q == '0;
	assign dp_status.probe_done = done;
	assign found                = found_q;
	assign position             = position_q;
	assign full                 = count_q == CW'(DEPTH);

	// An append never reaches a full table
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.append |-> count_q < CW'(DEPTH))
		else $error("append issued to a full table");

	// Every probe stays inside the written part of the table and its bounds
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.probe |-> (CW'(mid_q) < count_q) && lo_q <= mid_q && mid_q <= hi_q)
		else $error("probe index outside search range");

endmodule

// ----- sv/sbs_ctrl.sv -----
// ============================================================================
// sbs_ctrl
// Command decode, search sequencer and response handshake.
// ============================================================================
module sbs_ctrl
	import sbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [CMD_W-1:0] cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dp_cmd_t          dp_cmd,
	input  dp_status_t       dp_status
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   take, out_free;

	assign take     = req_valid && (state_q == ST_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					dp_cmd.clear  = cmd == CMD_CLEAR;
					dp_cmd.append = (cmd == CMD_APPEND);
					dp_cmd.start  = cmd == CMD_SEARCH;
					if (cmd == CMD_SEARCH) begin
						state_d = dp_status.cnt_zero ? ST_RESULT : ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				dp_cmd.read = 1'b1;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				dp_cmd.probe = 1'b1;
				if (dp_status.probe_done) begin
					state_d = ST_RESULT;
				end else begin
					dp_cmd.read = 1'b1;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the response word until taken; a new word may replace it as it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	// A response word appears only out of the result state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("response raised outside result state");

	// A finished search waits while the previous word is still stalled
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && rsp_valid_q && rsp_stall) |=> state_q == ST_RESULT)
		else $error("result overwrote a stalled response");

endmodule

// ----- sv/sorted_table_binary_search.sv -----
// ============================================================================
// sorted_table_binary_search
// Sorted element table with append, clear and binary search commands.
// ============================================================================
// Usage:
//   Request channel (req_valid, req_stall, cmd, value): a word is taken when
//   req_valid is high and req_stall low. cmd selects clear, append or search;
//   code 3 is dropped. Append elements in ascending order; an append to a
//   full table is dropped.
//   Response channel (rsp_valid, rsp_stall, found, position): one word per
//   search, none for clear or append. position holds the hit index, else 0.
// Timing:
//   Clear and append are applied as taken; the next request is taken right
//   after. A search loads key and bounds, starts the table read, compares
//   (one table read per cycle) until a hit or an empty range, then loads the
//   response register once the output is free; an empty table goes straight
//   to the response. The single read port of the table sets the probe rate.
//   Requests are stalled while a search runs; clear and append are still
//   taken while a response word waits on rsp_stall.
// Reset:
//   arst_n empties the table and drops any pending response. Table contents
//   are not cleared; only entries below the fill count are ever read.
//   When the receiver stalls, hold the response word; a finished search then
//   waits in its result state until the word is taken.
// ============================================================================
module sorted_table_binary_search
	import sbs_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VALUE_W-1:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               found,
	output logic [POS_W-1:0]   position
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;
	dp_cmd_t    dp_cmd_gated;

	// Drop an append when the table is full; the datapath count tells
	logic full;

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	always_comb begin
		dp_cmd_gated        = dp_cmd;
		dp_cmd_gated.append = dp_cmd.append && !full;
	end

	sbs_datapath #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd_gated),
		.dp_status (dp_status),
		.value     (value),
		.found     (found),
		.position  (position),
		.full      (full)
	);

endmodule
